// ===== src/vtn_pkg.sv =====
// Shared types and constants for the vector transform and normalise block.
// Used by every module under src except vtn_check; depends on nothing else.
package vtn_pkg;

  localparam int VEC_W       = 32;   // Q16.16 vector component
  localparam int MAT_W       = 16;   // Q2.14 matrix element
  localparam int PROD_W      = VEC_W + MAT_W;
  localparam int SQ_W        = 2 * VEC_W;
  localparam int REM_W       = VEC_W + 2;
  localparam int NORM_W      = 16;
  localparam int Q_W         = 15;   // quotient bits, enough for one in Q2.14
  localparam int NUM_W       = VEC_W + 14;
  localparam int MINLEN_W    = 16;
  localparam int FRONT_LAT   = 4;
  localparam int SQRT_CELLS  = VEC_W;
  localparam int DIV_CELLS   = Q_W;
  localparam int PIPE_DEPTH  = FRONT_LAT + SQRT_CELLS + 1 + DIV_CELLS;

  localparam logic [MINLEN_W-1:0] MINLEN_RESET = 16'd66;
  localparam logic [Q_W-1:0]      UNIT_Q14     = 15'd16384;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] c1;
    logic signed [MAT_W-1:0] c2;
    logic signed [MAT_W-1:0] c3;
  } row_t;

  // Square root working set: radicand still to consume, partial remainder and root.
  typedef struct packed {
    logic [SQ_W-1:0]  rad;
    logic [REM_W-1:0] rem;
    logic [VEC_W-1:0] root;
  } sqs_t;

  // One division lane: partial remainder, numerator bits still to bring down, quotient.
  typedef struct packed {
    logic [VEC_W:0]   rem;
    logic [Q_W-1:0]   nb;
    logic [Q_W-1:0]   q;
  } dlane_t;

  typedef struct packed {
    logic [VEC_W-1:0] len;
    logic [2:0]       neg;
    logic             short_len;
  } dctl_t;

endpackage

// ===== src/vtn_front.sv =====
// Front end: matrix product, Q16.16 saturation and sum of squares in four stages.
// Depends on vtn_pkg.
module vtn_front (
  input  logic          clk,
  input  logic          en,
  input  vtn_pkg::vec_t v_i,
  input  vtn_pkg::row_t r1_i,
  input  vtn_pkg::row_t r2_i,
  input  vtn_pkg::row_t r3_i,
  output vtn_pkg::vec_t t_o,
  output logic [vtn_pkg::SQ_W-1:0] sq_o
);

  logic signed [vtn_pkg::VEC_W-1:0]  vv [3];
  logic signed [vtn_pkg::MAT_W-1:0]  mm [3][3];
  logic signed [vtn_pkg::PROD_W-1:0] p_r [3][3];
  logic signed [vtn_pkg::VEC_W-1:0]  t_nxt [3];
  logic signed [vtn_pkg::VEC_W-1:0]  t2_r [3];
  logic signed [vtn_pkg::VEC_W-1:0]  t3_r [3];
  logic [vtn_pkg::SQ_W-1:0]          sq3_r [3];
  logic [vtn_pkg::SQ_W-1:0]          sq_nxt [3];
  vtn_pkg::vec_t                     t4_r;
  logic [vtn_pkg::SQ_W-1:0]          sum4_r;

  always_comb begin
    vv[0] = v_i.x; vv[1] = v_i.y; vv[2] = v_i.z;
    mm[0][0] = r1_i.c1; mm[0][1] = r1_i.c2; mm[0][2] = r1_i.c3;
    mm[1][0] = r2_i.c1; mm[1][1] = r2_i.c2; mm[1][2] = r2_i.c3;
    mm[2][0] = r3_i.c1; mm[2][1] = r3_i.c2; mm[2][2] = r3_i.c3;
  end

  // Column sums, floor shift by 14 and saturation to the 32-bit range.
  always_comb begin
    logic signed [vtn_pkg::PROD_W+1:0] s;
    logic signed [vtn_pkg::PROD_W-13:0] sh;
    for (int j = 0; j < 3; j++) begin
      s = {{2{p_r[0][j][vtn_pkg::PROD_W-1]}}, p_r[0][j]}
        + {{2{p_r[1][j][vtn_pkg::PROD_W-1]}}, p_r[1][j]}
        + {{2{p_r[2][j][vtn_pkg::PROD_W-1]}}, p_r[2][j]};
      sh = s[vtn_pkg::PROD_W+1:14];
      if (sh[vtn_pkg::PROD_W-13:vtn_pkg::VEC_W-1] == '0 ||
          sh[vtn_pkg::PROD_W-13:vtn_pkg::VEC_W-1] == '1) begin
        t_nxt[j] = sh[vtn_pkg::VEC_W-1:0];
      end else if (sh[vtn_pkg::PROD_W-13]) begin
        t_nxt[j] = {1'b1, {(vtn_pkg::VEC_W-1){1'b0}}};
      end else begin
        t_nxt[j] = {1'b0, {(vtn_pkg::VEC_W-1){1'b1}}};
      end
    end
  end

  always_comb begin
    logic [vtn_pkg::VEC_W-1:0] mag;
    for (int j = 0; j < 3; j++) begin
      mag = t2_r[j][vtn_pkg::VEC_W-1] ? (~t2_r[j] + 1'b1) : t2_r[j];
      sq_nxt[j] = mag * mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[i][j] <= vv[i] * mm[i][j];
        end
      end
      t2_r   <= t_nxt;
      t3_r   <= t2_r;
      sq3_r  <= sq_nxt;
      t4_r   <= '{x: t3_r[0], y: t3_r[1], z: t3_r[2]};
      sum4_r <= sq3_r[0] + sq3_r[1] + sq3_r[2];
    end
  end

  assign t_o  = t4_r;
  assign sq_o = sum4_r;

endmodule

// ===== src/vtn_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per cell.
// Depends on vtn_pkg.
module vtn_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  vtn_pkg::sqs_t  d_i,
  input  vtn_pkg::vec_t  t_i,
  output vtn_pkg::sqs_t  d_o,
  output vtn_pkg::vec_t  t_o
);

  vtn_pkg::sqs_t d_nxt;
  vtn_pkg::sqs_t d_r;
  vtn_pkg::vec_t t_r;

  always_comb begin
    logic [vtn_pkg::REM_W-1:0] r2;
    logic [vtn_pkg::REM_W-1:0] trial;
    r2    = {d_i.rem[vtn_pkg::VEC_W-1:0], d_i.rad[vtn_pkg::SQ_W-1 -: 2]};
    trial = {d_i.root, 2'b01};
    d_nxt.rad = {d_i.rad[vtn_pkg::SQ_W-3:0], 2'b00};
    if (r2 >= trial) begin
      d_nxt.rem  = r2 - trial;
      d_nxt.root = {d_i.root[vtn_pkg::VEC_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = r2;
      d_nxt.root = {d_i.root[vtn_pkg::VEC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      t_r <= t_i;
    end
  end

  assign d_o = d_r;
  assign t_o = t_r;

endmodule

// ===== src/vtn_div_cell.sv =====
// One cell of the division chain: one quotient bit for each of three lanes.
// Depends on vtn_pkg.
module vtn_div_cell (
  input  logic                   clk,
  input  logic                   en,
  input  vtn_pkg::dlane_t [2:0]  l_i,
  input  vtn_pkg::dctl_t         c_i,
  output vtn_pkg::dlane_t [2:0]  l_o,
  output vtn_pkg::dctl_t         c_o
);

  vtn_pkg::dlane_t [2:0] l_nxt;
  vtn_pkg::dlane_t [2:0] l_r;
  vtn_pkg::dctl_t        c_r;

  always_comb begin
    logic [vtn_pkg::VEC_W:0] r2;
    for (int k = 0; k < 3; k++) begin
      r2 = {l_i[k].rem[vtn_pkg::VEC_W-1:0], l_i[k].nb[vtn_pkg::Q_W-1]};
      l_nxt[k].nb = {l_i[k].nb[vtn_pkg::Q_W-2:0], 1'b0};
      if (r2 >= {1'b0, c_i.len}) begin
        l_nxt[k].rem = r2 - {1'b0, c_i.len};
        l_nxt[k].q   = {l_i[k].q[vtn_pkg::Q_W-2:0], 1'b1};
      end else begin
        l_nxt[k].rem = r2;
        l_nxt[k].q   = {l_i[k].q[vtn_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= l_nxt;
      c_r <= c_i;
    end
  end

  assign l_o = l_r;
  assign c_o = c_r;

endmodule

// ===== src/vector_transform_normalize.sv =====
// Top level of the vector transform and normalise block.
// Depends on vtn_pkg, vtn_front, vtn_sqrt_cell and vtn_div_cell.
//
// Each request carries a signed Q16.16 vector and a signed Q2.14 3x3 matrix; the
// vector is multiplied as a row vector by the matrix, each sum is floored to
// Q16.16 and saturated, the floored integer length is found by a chain of 32
// square root cells (one root bit each), and each component is divided by the
// length in a chain of 15 division cells (one quotient bit each, three lanes),
// giving Q2.14 unit components rounded half away from zero. When the length is
// zero or below min_length, all components are zero and too_short is set. The
// block takes one request every cycle while the skid entry is empty; each result
// passes through 53 register stages (4 front stages, 32 root cells, one set-up
// stage, 15 division cells, one output register) on its way to the output. A
// two-entry output stage (register and skid) decouples the sides: in_tready falls
// only once a result is waiting and a second one has arrived behind it.
// min_length is written through cfg_we and cfg_wdata and should only be changed
// while no request is in flight.
module vector_transform_normalize (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vec_x, vec_y, vec_z, m_r1c1, m_r1c2, m_r1c3, m_r2c1, m_r2c2, m_r2c3,
  // m_r3c1, m_r3c2, m_r3c3
  input  logic [239:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // norm_x, norm_y, norm_z
  output logic [47:0]  out_tdata,
  // too_short
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  logic                           en;
  logic [vtn_pkg::MINLEN_W-1:0]   min_len_r;
  logic [vtn_pkg::PIPE_DEPTH-1:0] vld_r;
  vtn_pkg::vec_t                  vin;
  vtn_pkg::row_t                  r1, r2, r3;
  vtn_pkg::vec_t                  tf;
  logic [vtn_pkg::SQ_W-1:0]       sqf;
  vtn_pkg::sqs_t                  sq_c [vtn_pkg::SQRT_CELLS+1];
  vtn_pkg::vec_t                  tv_c [vtn_pkg::SQRT_CELLS+1];
  vtn_pkg::dlane_t [2:0]          dl_c [vtn_pkg::DIV_CELLS+1];
  vtn_pkg::dctl_t                 dc_c [vtn_pkg::DIV_CELLS+1];
  vtn_pkg::dlane_t [2:0]          prep_nxt;
  vtn_pkg::dctl_t                 prepc_nxt;
  vtn_pkg::dlane_t [2:0]          prep_r;
  vtn_pkg::dctl_t                 prepc_r;
  logic [47:0]                    res_data;
  logic                           res_short;
  logic                           out_valid_r;
  logic [47:0]                    out_data_r;
  logic                           out_short_r;
  logic                           skid_valid_r;
  logic [47:0]                    skid_data_r;
  logic                           skid_short_r;
  logic                           take;

  // The pipeline moves as one; it stops only while the skid entry is occupied.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  assign vin = '{x: in_tdata[31:0], y: in_tdata[63:32], z: in_tdata[95:64]};
  assign r1  = '{c1: in_tdata[111:96],  c2: in_tdata[127:112], c3: in_tdata[143:128]};
  assign r2  = '{c1: in_tdata[159:144], c2: in_tdata[175:160], c3: in_tdata[191:176]};
  assign r3  = '{c1: in_tdata[207:192], c2: in_tdata[223:208], c3: in_tdata[239:224]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= vtn_pkg::MINLEN_RESET;
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  // Valid flags travel alongside the data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[vtn_pkg::PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  vtn_front u_front (
    .clk  (clk),
    .en   (en),
    .v_i  (vin),
    .r1_i (r1),
    .r2_i (r2),
    .r3_i (r3),
    .t_o  (tf),
    .sq_o (sqf)
  );

  assign sq_c[0] = '{rad: sqf, rem: '0, root: '0};
  assign tv_c[0] = tf;

  for (genvar g = 0; g < vtn_pkg::SQRT_CELLS; g++) begin : g_sqrt
    vtn_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d_i (sq_c[g]),
      .t_i (tv_c[g]),
      .d_o (sq_c[g+1]),
      .t_o (tv_c[g+1])
    );
  end

  // Division set-up: numerator is |t| * 2^14 plus half the length, so the
  // truncating division rounds half away from zero. Its top bits already sit
  // below the length, so only fifteen quotient bits remain to be found.
  always_comb begin
    logic [vtn_pkg::VEC_W-1:0]  len;
    logic signed [vtn_pkg::VEC_W-1:0] tc [3];
    logic [vtn_pkg::VEC_W-1:0]  mag;
    logic [vtn_pkg::NUM_W-1:0]  num;
    len   = sq_c[vtn_pkg::SQRT_CELLS].root;
    tc[0] = tv_c[vtn_pkg::SQRT_CELLS].x;
    tc[1] = tv_c[vtn_pkg::SQRT_CELLS].y;
    tc[2] = tv_c[vtn_pkg::SQRT_CELLS].z;
    for (int k = 0; k < 3; k++) begin
      mag = tc[k][vtn_pkg::VEC_W-1] ? (~tc[k] + 1'b1) : tc[k];
      num = {mag, 14'b0} + {{(vtn_pkg::NUM_W-vtn_pkg::VEC_W+1){1'b0}},
                            len[vtn_pkg::VEC_W-1:1]};
      prep_nxt[k].rem = {2'b00, num[vtn_pkg::NUM_W-1:vtn_pkg::Q_W]};
      prep_nxt[k].nb  = num[vtn_pkg::Q_W-1:0];
      prep_nxt[k].q   = '0;
      prepc_nxt.neg[k] = tc[k][vtn_pkg::VEC_W-1];
    end
    prepc_nxt.len       = len;
    prepc_nxt.short_len = (len == '0) ||
                          (len < {{(vtn_pkg::VEC_W-vtn_pkg::MINLEN_W){1'b0}}, min_len_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r  <= prep_nxt;
      prepc_r <= prepc_nxt;
    end
  end

  assign dl_c[0] = prep_r;
  assign dc_c[0] = prepc_r;

  for (genvar g = 0; g < vtn_pkg::DIV_CELLS; g++) begin : g_div
    vtn_div_cell u_cell (
      .clk (clk),
      .en  (en),
      .l_i (dl_c[g]),
      .c_i (dc_c[g]),
      .l_o (dl_c[g+1]),
      .c_o (dc_c[g+1])
    );
  end

  // Clamp to one, apply the sign, and zero everything for a short vector.
  always_comb begin
    logic [vtn_pkg::Q_W-1:0]    qs;
    logic [vtn_pkg::NORM_W-1:0] val;
    vtn_pkg::dlane_t [2:0]      lf;
    vtn_pkg::dctl_t             cf;
    lf = dl_c[vtn_pkg::DIV_CELLS];
    cf = dc_c[vtn_pkg::DIV_CELLS];
    res_data = '0;
    for (int k = 0; k < 3; k++) begin
      qs  = (lf[k].q > vtn_pkg::UNIT_Q14) ? vtn_pkg::UNIT_Q14 : lf[k].q;
      val = {1'b0, qs};
      if (cf.neg[k]) begin
        val = ~val + 1'b1;
      end
      if (!cf.short_len) begin
        res_data[k*vtn_pkg::NORM_W +: vtn_pkg::NORM_W] = val;
      end
    end
    res_short = cf.short_len;
  end

  // Output register with a skid entry behind it.
  assign take = out_tready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (vld_r[vtn_pkg::PIPE_DEPTH-1]) begin
      if (take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r  <= skid_data_r;
        out_short_r <= skid_short_r;
      end
    end else if (vld_r[vtn_pkg::PIPE_DEPTH-1]) begin
      if (take) begin
        out_data_r  <= res_data;
        out_short_r <= res_short;
      end else begin
        skid_data_r  <= res_data;
        skid_short_r <= res_short;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_short_r;

endmodule

// ===== src/vtn_check.sv =====
// Port-level checks for the vector transform and normalise block.
// Attached to vector_transform_normalize by the bind statement at the end.
module vtn_check (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [239:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic [0:0]   out_tuser,
  input logic         cfg_we,
  input logic [15:0]  cfg_wdata
);

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 48'd0)
    else $error("short vector result with non-zero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[15:0])  <= 16'sd16384) && ($signed(out_tdata[15:0])  >= -16'sd16384) &&
      ($signed(out_tdata[31:16]) <= 16'sd16384) && ($signed(out_tdata[31:16]) >= -16'sd16384) &&
      ($signed(out_tdata[47:32]) <= 16'sd16384) && ($signed(out_tdata[47:32]) >= -16'sd16384))
    else $error("unit component beyond one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind vector_transform_normalize vtn_check u_vtn_check (.*);

// ===== dv/testbench.sv =====
// Self-checking bench for vector_transform_normalize: drives random and corner
// requests, predicts each unit vector and short flag, compares on the output side.
// Depends on vtn_pkg and the RTL under src.
module testbench;

  // One request as it travels on in_tdata.
  typedef struct {
    logic signed [31:0] v[3];
    logic signed [15:0] m[9];
  } request_t;

  // One predicted result.
  typedef struct {
    logic [15:0] n[3];
    logic        short_flag;
  } unit_t;

  localparam int SETTLE_CYCLES = vtn_pkg::PIPE_DEPTH + 10;
  localparam int WATCHDOG_MAX  = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [239:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;

  request_t pending_reqs[$];
  unit_t    expected_units[$];
  logic [15:0] min_len_model;
  int  errors;
  int  idle_cycles;
  bit  quiet_phase;     // no idling on either side in the final stretch
  bit  hold_receiver;   // request for a long receiver stall
  int  hold_count;
  int  tx_gap;
  int  rx_gap;

  vector_transform_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [239:0] pack_request(request_t r);
    logic [239:0] d;
    d = '0;
    for (int i = 0; i < 3; i++) d[32*i +: 32] = r.v[i];
    for (int i = 0; i < 9; i++) d[96 + 16*i +: 16] = r.m[i];
    return d;
  endfunction

  // Q20.30 sum floored to Q16.16 and clamped to 32 bits. An arithmetic shift
  // is a floor, which is exactly the rounding that is wanted.
  function automatic longint floor_saturate(longint s);
    longint r;
    r = s >>> 14;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic unit_t predict_unit(request_t r, logic [15:0] min_len);
    unit_t u;
    longint t[3];
    longint unsigned mag[3];
    longint unsigned sumsq;
    longint unsigned len;
    longint unsigned q;
    sumsq = 0;
    for (int j = 0; j < 3; j++) begin
      t[j] = floor_saturate(longint'(r.v[0]) * r.m[j] + longint'(r.v[1]) * r.m[3+j]
                            + longint'(r.v[2]) * r.m[6+j]);
      mag[j] = (t[j] < 0) ? longint'(-t[j]) : t[j];
      sumsq += mag[j] * mag[j];
    end
    len = floor_root(sumsq);
    if (len == 0 || len < min_len) begin
      for (int j = 0; j < 3; j++) u.n[j] = '0;
      u.short_flag = 1'b1;
    end else begin
      for (int j = 0; j < 3; j++) begin
        q = (mag[j] * 16384 + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        u.n[j] = (t[j] < 0) ? 16'(-q) : 16'(q);
      end
      u.short_flag = 1'b0;
    end
    return u;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int shape;
    for (int i = 0; i < 3; i++) begin
      shape = $urandom_range(0, 3);
      case (shape)
        0: r.v[i] = $urandom;
        1: r.v[i] = $signed($urandom_range(0, 2000)) - 1000;
        2: r.v[i] = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        default: r.v[i] = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      endcase
    end
    for (int i = 0; i < 9; i++) begin
      shape = $urandom_range(0, 5);
      case (shape)
        0: r.m[i] = 16'sh4000;
        1: r.m[i] = '0;
        2: r.m[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: r.m[i] = $urandom;
      endcase
    end
    return r;
  endfunction

  function automatic request_t make_request(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z, logic signed [15:0] diag,
                                            logic signed [15:0] off);
    request_t r;
    r.v[0] = x;
    r.v[1] = y;
    r.v[2] = z;
    for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? diag : off;
    return r;
  endfunction

  // Driver: presents the head of the request queue; random bursts of gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_units.push_back(predict_unit(pending_reqs.pop_front(), min_len_model));
      end
      if (!(in_tvalid && !in_tready)) begin
        if (tx_gap > 0) begin
          tx_gap    <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
          tx_gap    <= $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > (in_tvalid && in_tready ? 0 : 0)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pack_request(pending_reqs[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    unit_t exp_u;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
      hold_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_units.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h/%b", $time,
                   out_tdata, out_tuser);
          errors++;
        end else begin
          exp_u = expected_units.pop_front();
          for (int j = 0; j < 3; j++)
            if (out_tdata[16*j +: 16] !== exp_u.n[j]) begin
              $display("%0t: component %0d expected %h actual %h", $time, j,
                       exp_u.n[j], out_tdata[16*j +: 16]);
              errors++;
            end
          if (out_tuser[0] !== exp_u.short_flag) begin
            $display("%0t: too_short expected %b actual %b", $time,
                     exp_u.short_flag, out_tuser[0]);
            errors++;
          end
        end
      end
      if (hold_receiver && hold_count == 0) begin
        hold_count <= 300;
        out_tready <= 1'b0;
      end else if (hold_count > 1) begin
        hold_count <= hold_count - 1;
        out_tready <= 1'b0;
      end else if (hold_count == 1) begin
        hold_count <= 0;
        out_tready <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap     <= rx_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        rx_gap     <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_units.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_length(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_len_model = value;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending_reqs.push_back(random_request());
  endtask

  initial begin
    logic [15:0] settings[4];
    errors        = 0;
    quiet_phase   = 1'b0;
    hold_receiver = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    min_len_model = vtn_pkg::MINLEN_RESET;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero vector, identity, extremes, saturation, tiny vectors
    // near the reset threshold, overshoot of the unit magnitude.
    pending_reqs.push_back(make_request(0, 0, 0, 16'sh4000, 0));
    pending_reqs.push_back(make_request(32'sh0001_0000, 0, 0, 16'sh4000, 0));
    pending_reqs.push_back(make_request(0, -32'sh0001_0000, 0, 16'sh4000, 0));
    pending_reqs.push_back(make_request(65, 0, 0, 16'sh4000, 0));
    pending_reqs.push_back(make_request(66, 0, 0, 16'sh4000, 0));
    pending_reqs.push_back(make_request(-40, 40, 40, 16'sh4000, 0));
    pending_reqs.push_back(make_request(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                        16'sh7fff, 16'sh7fff));
    pending_reqs.push_back(make_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        16'sh8000, 16'sh8000));
    pending_reqs.push_back(make_request(32'sh8000_0000, 32'sh7fff_ffff, 1,
                                        16'sh8000, 16'sh7fff));
    pending_reqs.push_back(make_request(3, 3, 3, 16'sh4000, 0));
    pending_reqs.push_back(make_request(1, 1, 0, 16'sh4000, 0));
    pending_reqs.push_back(make_request(32'sh0001_0000, 32'sh0001_0000, 0,
                                        16'sh0001, 16'shffff));
    pending_reqs.push_back(make_request(-1, -1, -1, 16'sh0001, 0));
    pending_reqs.push_back(make_request(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ffff,
                                        16'sh2d41, -16'sh2d41));
    wait_drained();

    // Sweep of thresholds including both extremes; the sender pauses at each
    // step until every result is in.
    settings = '{16'd0, 16'd65535, 16'd1000, vtn_pkg::MINLEN_RESET};
    foreach (settings[k]) begin
      write_min_length(settings[k]);
      pending_reqs.push_back(make_request(0, 0, 0, 16'sh4000, 0));
      pending_reqs.push_back(make_request(32'sh0000_ffff, 0, 0, 16'sh4000, 0));
      pending_reqs.push_back(make_request(999, 0, 0, 16'sh4000, 0));
      pending_reqs.push_back(make_request(1000, 0, 0, 16'sh4000, 0));
      queue_random(400);
      if (k == 1) begin
        // Long receiver stall while requests keep coming, to back up the pipe.
        // The flag stays up until the monitor has started counting the stall.
        hold_receiver = 1'b1;
        wait (hold_count != 0);
        hold_receiver = 1'b0;
      end
      wait_drained();
    end

    quiet_phase = 1'b1;
    queue_random(300);
    wait_drained();

    if (errors == 0 && expected_units.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
